// File: design/cqe_pkg.sv
package cqe_pkg;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_DISPLAY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_EMIT = 1'b1
   } seq_state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data;
      logic               last;
   } rsp_type;

endpackage

// File: design/circular_queue_engine_unit.sv
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     cqe_pkg::req_type (cmd, value)
// rsp       out        rsp_valid / rsp_stall     cqe_pkg::rsp_type (status, data, last)
//
// enqueue and every error answer are loaded into the output register at the accept edge.
// dequeue, peek and display first read the head slot through the single read port of the
// slot memory into registered read data, then emit it; display emits every word, head to tail.
// one transaction is in work at a time; req_stall is high while a slot-reading command runs.
// reset clears head, tail, occupancy, the sequencer and result valid; the slot memory keeps its contents.
// a stalled result holds in the output register; a new command is taken as it drains.
module circular_queue_engine_unit #(
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cqe_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cqe_pkg::rsp_type rsp
);
   import cqe_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic signed [31:0] mem [DEPTH];

   seq_state_type      state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [31:0] rd_data_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               out_free;
   logic               req_fire;
   logic               emit_fire;
   logic               is_full;
   logic               is_empty;
   logic               emit_last;
   logic               mem_we;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   inc_src;
   logic [IDX_W-1:0]   inc_res;

   // shared wrap incrementer for tail and read pointer
   always_comb begin
      inc_src = (state_ff == SEQ_IDLE) ? tail_ff : ptr_ff;
      if (inc_src == IDX_W'(DEPTH - 1)) begin
         inc_res = '0;
      end else begin
         inc_res = inc_src + IDX_W'(1);
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == SEQ_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;
   assign emit_fire = (state_ff == SEQ_EMIT) && out_free;
   assign is_full   = (occ_ff == CNT_W'(DEPTH));
   assign is_empty  = (occ_ff == '0);
   assign emit_last = (cmd_ff != CMD_DISPLAY) || (cnt_ff == CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_fire && (req.cmd != CMD_ENQUEUE) && !is_empty) begin
               state_in = SEQ_EMIT;
            end
         end
         SEQ_EMIT: begin
            if (emit_fire && emit_last) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      cmd_in       = cmd_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ptr_in       = ptr_ff;
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               cmd_in = req.cmd;
               ptr_in = head_ff;
               cnt_in = occ_ff;
               if (req.cmd == CMD_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.data  = '0;
                  rsp_in.last  = 1'b1;
                  if (is_full) begin
                     rsp_in.status = ST_OVERFLOW;
                  end else begin
                     rsp_in.status = ST_OK;
                     mem_we        = 1'b1;
                     tail_in       = inc_res;
                     occ_in        = occ_ff + CNT_W'(1);
                  end
               end else if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_EMPTY;
                  rsp_in.data   = '0;
                  rsp_in.last   = 1'b1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = head_ff;
               end
            end
         end
         SEQ_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_OK;
               rsp_in.data   = rd_data_ff;
               rsp_in.last   = emit_last;
               cnt_in        = cnt_ff - CNT_W'(1);
               ptr_in        = inc_res;
               rd_en         = 1'b1;
               rd_addr       = inc_res;
               if (cmd_ff == CMD_DEQUEUE) begin
                  head_in = inc_res;
                  occ_in  = occ_ff + {CNT_W{1'b1}};
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= req.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ptr_ff <= ptr_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: design/cqe_checker.sv
module cqe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input cqe_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cqe_pkg::rsp_type rsp
);
   import cqe_pkg::*;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

   // an error answer is a single result
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != ST_OK) |-> rsp.last)
      else $error("error result without last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != ST_OK) |-> (rsp.data == '0))
      else $error("error result with nonzero data");

   // enqueue answers on the very next cycle with a single zero-data result
   a_enq_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req.cmd == CMD_ENQUEUE)
      |=> rsp_valid && rsp.last && (rsp.data == '0) && (rsp.status != ST_EMPTY))
      else $error("enqueue answer missing or malformed");

endmodule

bind circular_queue_engine_unit cqe_checker u_cqe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// File: tb/sv/circular_queue_engine_checker.sv
module circular_queue_engine_checker #(
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  cqe_pkg::req_type req,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  cqe_pkg::rsp_type rsp,
   output int               failures,
   output int               pending
);
   import cqe_pkg::*;

   logic signed [31:0] ring_words [DEPTH];
   int                 ring_head;
   int                 ring_tail;
   int                 ring_count;
   int                 fail_total;
   rsp_type            awaited_answers [$];

   function automatic rsp_type make_answer(status_type st, logic signed [31:0] word,
                                           logic final_mark);
      rsp_type answer;
      answer.status = st;
      answer.data   = word;
      answer.last   = final_mark;
      return answer;
   endfunction

   task automatic predict_answers(input req_type item);
      if (item.cmd == CMD_ENQUEUE) begin
         if (ring_count >= DEPTH) begin
            awaited_answers.push_back(make_answer(ST_OVERFLOW, '0, 1'b1));
         end else begin
            ring_words[ring_tail] = item.value;
            ring_tail  = (ring_tail + 1) % DEPTH;
            ring_count = ring_count + 1;
            awaited_answers.push_back(make_answer(ST_OK, '0, 1'b1));
         end
      end else if (ring_count == 0) begin
         awaited_answers.push_back(make_answer(ST_EMPTY, '0, 1'b1));
      end else begin
         case (item.cmd)
            CMD_DEQUEUE: begin
               awaited_answers.push_back(make_answer(ST_OK, ring_words[ring_head], 1'b1));
               ring_head  = (ring_head + 1) % DEPTH;
               ring_count = ring_count - 1;
            end
            CMD_PEEK: begin
               awaited_answers.push_back(make_answer(ST_OK, ring_words[ring_head], 1'b1));
            end
            default: begin
               // display walks head to tail, only the tail word is marked
               for (int k = 0; k < ring_count; k++) begin
                  awaited_answers.push_back(make_answer(ST_OK,
                     ring_words[(ring_head + k) % DEPTH], k == ring_count - 1));
               end
            end
         endcase
      end
   endtask

   function automatic void report_mismatch(string field_name, longint want, longint got);
      $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
      fail_total = fail_total + 1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ring_head  = 0;
         ring_tail  = 0;
         ring_count = 0;
         fail_total = 0;
         awaited_answers.delete();
      end else begin
         // a result accepted now always belongs to an earlier transaction
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               $error("unexpected result transaction: status %0d data %0d last %0d",
                      rsp.status, rsp.data, rsp.last);
               fail_total = fail_total + 1;
            end else begin
               want = awaited_answers.pop_front();
               if (rsp.status !== want.status)
                  report_mismatch("status", want.status, rsp.status);
               if (rsp.data !== want.data)
                  report_mismatch("data", want.data, rsp.data);
               if (rsp.last !== want.last)
                  report_mismatch("last", want.last, rsp.last);
            end
         end
         if (req_valid && !req_stall) begin
            predict_answers(req);
         end
      end
      failures <= fail_total;
      pending  <= awaited_answers.size();
   end

endmodule

// File: tb/sv/circular_queue_engine_unit_test.sv
module circular_queue_engine_unit_test;
   import cqe_pkg::*;

   localparam int DEPTH          = 8;
   localparam int RANDOM_ITEMS   = 250;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   int failures;
   int pending;
   int idle_cycles     = 0;
   int stall_countdown = 0;
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;

   circular_queue_engine_unit #(
      .DEPTH(DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   circular_queue_engine_checker #(
      .DEPTH(DEPTH)
   ) queue_answer_check (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: after each transaction hold stall for a random number of cycles
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_stall       <= 1'b0;
         stall_countdown <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 39) == 0) receiver_steady = ~receiver_steady;
         hold = receiver_steady ? 0 : $urandom_range(0, 5);
         stall_countdown <= hold;
         rsp_stall       <= (hold != 0);
      end else if (stall_countdown > 0) begin
         stall_countdown <= stall_countdown - 1;
         rsp_stall       <= (stall_countdown > 1);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_command(input cmd_type op, input logic signed [31:0] word);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_steady = ~sender_steady;
      gap = sender_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= '{cmd: op, value: word};
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   initial begin
      int      roll;
      int      phase;
      cmd_type op;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // display, dequeue and peek on an empty queue
      send_command(CMD_DISPLAY, $urandom);
      send_command(CMD_DEQUEUE, $urandom);
      send_command(CMD_PEEK, $urandom);
      // fill to the brim with extreme words, then overflow
      send_command(CMD_ENQUEUE, 32'sh7FFF_FFFF);
      send_command(CMD_ENQUEUE, 32'sh8000_0000);
      send_command(CMD_ENQUEUE, 32'sh0000_0000);
      send_command(CMD_ENQUEUE, -32'sd1);
      send_command(CMD_ENQUEUE, 32'sh0000_0001);
      send_command(CMD_ENQUEUE, 32'sh5555_5555);
      send_command(CMD_ENQUEUE, 32'shAAAA_AAAA);
      send_command(CMD_ENQUEUE, 32'sh1234_5678);
      send_command(CMD_ENQUEUE, 32'sh0BAD_F00D);
      send_command(CMD_PEEK, $urandom);
      send_command(CMD_DISPLAY, $urandom);
      // free two slots and refill them at the start of the ring, so display walks across the wrap
      send_command(CMD_DEQUEUE, $urandom);
      send_command(CMD_DEQUEUE, $urandom);
      send_command(CMD_ENQUEUE, 32'sh7654_3210);
      send_command(CMD_ENQUEUE, 32'shFEDC_BA98);
      send_command(CMD_DISPLAY, $urandom);
      send_command(CMD_DEQUEUE, $urandom);
      send_command(CMD_DEQUEUE, $urandom);
      send_command(CMD_DEQUEUE, $urandom);

      // phases lean toward filling, draining or a mix so full and empty both recur
      phase = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 30 == 0) phase = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         case (phase)
            0:       op = cmd_type'(roll < 60 ? CMD_ENQUEUE : roll < 80 ? CMD_DEQUEUE :
                                    roll < 90 ? CMD_PEEK : CMD_DISPLAY);
            1:       op = cmd_type'(roll < 20 ? CMD_ENQUEUE : roll < 75 ? CMD_DEQUEUE :
                                    roll < 88 ? CMD_PEEK : CMD_DISPLAY);
            default: op = cmd_type'(roll < 40 ? CMD_ENQUEUE : roll < 75 ? CMD_DEQUEUE :
                                    roll < 88 ? CMD_PEEK : CMD_DISPLAY);
         endcase
         send_command(op, op == CMD_ENQUEUE ? pick_word() : $urandom);
      end
      req_valid <= 1'b0;

      // let the pending count take in the last transaction before polling it
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
